@@ hw/rtl/svv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package svv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int COEF_W        = 31;
  localparam int PROD_W        = COEF_W + DATA_W;
  // quotient bits kept; a quotient at or above 2**QUO_W is replaced by 2**QUO_W
  localparam int QUO_W         = 34;
  localparam int HI_W          = PROD_W - QUO_W;
  localparam int IDX_W         = 2;

  typedef enum logic [1:0] {
    CMD_FIRST   = 2'd0,
    CMD_SECOND  = 2'd1,
    CMD_CORRECT = 2'd2,
    CMD_SCALAR  = 2'd3
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DTF   = 2'd0,
    REG_DTV   = 2'd1,
    REG_REMAP = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic                     grp;
    logic [COEF_W-1:0]        dvsr;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] ve;
    logic signed [DATA_W-1:0] rho;
    logic signed [DATA_W-1:0] e;
    logic                     f_neg;
    logic [PROD_W-1:0]        p;
    logic                     rho_neg;
    logic [PROD_W-1:0]        prho;
    logic                     e_neg;
    logic [PROD_W-1:0]        pe;
    logic                     over;
    logic [COEF_W-1:0]        rem;
    logic [QUO_W-1:0]         q;
    logic                     x_neg;
    logic [PROD_W-1:0]        px;
  } work_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] a);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (a > hi) sat32 = DATA_W'(hi);
      else if (a < lo) sat32 = DATA_W'(lo);
      else sat32 = a[DATA_W-1:0];
    end
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] a);
    begin
      mag32 = a[DATA_W-1] ? (~a + 1'b1) : a;
    end
  endfunction

  // product shifted right by frac, rounded toward minus infinity
  function automatic logic signed [63:0] mulq_fin(input logic [PROD_W-1:0] p,
                                                  input logic neg, input int frac);
    logic [63:0] ext;
    logic [63:0] unit;
    begin
      ext  = 64'(p);
      unit = 64'd1 << frac;
      if (neg) mulq_fin = -$signed((ext + unit - 64'd1) >> frac);
      else     mulq_fin = $signed(ext >> frac);
    end
  endfunction

  // one restoring division step, quotient bit from product bit QUO_W-1-k
  function automatic work_t div_step(input work_t w, input int k);
    logic [COEF_W:0] t;
    logic [COEF_W:0] d;
    work_t           r;
    begin
      r = w;
      t = {w.rem, w.p[QUO_W-1-k]};
      d = {1'b0, w.dvsr};
      if (t >= d) begin
        t = t - d;
        r.q = {w.q[QUO_W-2:0], 1'b1};
      end else begin
        r.q = {w.q[QUO_W-2:0], 1'b0};
      end
      r.rem = t[COEF_W-1:0];
      div_step = r;
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/svv_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface svv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        in_group;
  logic [30:0] particle_mass;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] force_req;
  logic signed [31:0] velocity_estimate;
  logic signed [31:0] density;
  logic signed [31:0] density_rate;
  logic signed [31:0] energy;
  logic signed [31:0] energy_rate;
  modport source (output valid, cmd, in_group, particle_mass, position, velocity, force_req,
                  velocity_estimate, density, density_rate, energy, energy_rate,
                  input ready);
  modport sink (input valid, cmd, in_group, particle_mass, position, velocity, force_req,
                velocity_estimate, density, density_rate, energy, energy_rate,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/svv_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface svv_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] new_position;
  logic signed [31:0] new_velocity;
  logic signed [31:0] new_velocity_estimate;
  logic signed [31:0] new_density;
  logic signed [31:0] new_energy;
  modport source (output valid, new_position, new_velocity, new_velocity_estimate,
                  new_density, new_energy, input ready);
  modport sink (input valid, new_position, new_velocity, new_velocity_estimate,
                new_density, new_energy, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/svv_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface svv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/svv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module svv_div
  import svv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire work_t in_item,
  output logic       out_valid,
  output work_t      out_item
);

  logic [QUO_W-1:0] sv;
  work_t            st [QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(in_item, 0);
      for (int k = 1; k < QUO_W; k++) begin
        st[k] <= div_step(st[k-1], k);
      end
    end
  end

  assign out_valid = sv[QUO_W-1];
  assign out_item  = st[QUO_W-1];

endmodule
`default_nettype wire

@@ hw/rtl/sph_velocity_verlet_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  beat contents
// cfg      in   index, data (register write, always ready)
// req      in   cmd, group flag, mass, position, velocity, force, estimate, scalars
// rsp      out  new position, velocity, estimate, density, energy
//
// one item per cycle while the output register is empty or taken; the stages
// from accept to result valid are input reg, multiply, divide prep, 34 one-bit
// divider stages, velocity, position multiply, output reg; the 34-stage divider sets the depth
// all stages advance together while the output register is empty or taken
// synchronous reset clears valid bits and config registers
module sph_velocity_verlet_step
  import svv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  svv_cfg_if.sink  cfg,
  svv_req_if.sink  req,
  svv_rsp_if.source rsp
);

  logic [COEF_W-1:0] dtf;
  logic [COEF_W-1:0] dtv;
  logic              remap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dtf   <= '0;
      dtv   <= '0;
      remap <= 1'b0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_DTF:   dtf   <= cfg.data[COEF_W-1:0];
        REG_DTV:   dtv   <= cfg.data[COEF_W-1:0];
        REG_REMAP: remap <= cfg.data[0];
        default:   ;
      endcase
    end
  end

  logic  en;
  logic  v1, v2, v3, v4, v5, v6, v7;
  work_t w_in, w1, w2, w3, w4, w5, w6, w7;
  work_t n2, n3, n5, n6, n7;

  assign en        = !v7 || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_comb begin
    w_in       = '0;
    w_in.cmd   = cmd_t'(req.cmd);
    w_in.grp   = req.in_group;
    w_in.dvsr  = (req.particle_mass == '0) ? COEF_W'(1) : req.particle_mass;
    w_in.x     = req.position;
    w_in.v     = req.velocity;
    w_in.ve    = req.velocity_estimate;
    w_in.rho   = req.density;
    w_in.e     = req.energy;
    w_in.f_neg   = req.force_req[DATA_W-1];
    w_in.p       = PROD_W'(mag32(req.force_req));
    w_in.rho_neg = req.density_rate[DATA_W-1];
    w_in.prho    = PROD_W'(mag32(req.density_rate));
    w_in.e_neg   = req.energy_rate[DATA_W-1];
    w_in.pe      = PROD_W'(mag32(req.energy_rate));
  end

  // products of dtf with the magnitudes
  always_comb begin
    n2      = w1;
    n2.p    = PROD_W'(dtf) * w1.p;
    n2.prho = PROD_W'(dtf) * w1.prho;
    n2.pe   = PROD_W'(dtf) * w1.pe;
  end

  // scalar half step and divider seed
  always_comb begin
    n3 = w2;
    if (w2.grp && w2.cmd == CMD_SCALAR) begin
      n3.rho = sat32(64'(w2.rho) + mulq_fin(w2.prho, w2.rho_neg, FRAC_BITS));
      n3.e   = sat32(64'(w2.e) + mulq_fin(w2.pe, w2.e_neg, FRAC_BITS));
    end
    n3.over = {2'b00, w2.p[PROD_W-1 -: HI_W]} >= w2.dvsr;
    n3.rem  = COEF_W'(w2.p[PROD_W-1 -: HI_W]);
    n3.q    = '0;
  end

  svv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_item   (w3),
    .out_valid (v4),
    .out_item  (w4)
  );

  // velocity and estimate
  always_comb begin
    logic signed [63:0] mag;
    logic signed [63:0] dv;
    n5  = w4;
    mag = w4.over ? (64'sd1 <<< QUO_W) : $signed(64'(w4.q));
    dv  = w4.f_neg ? -mag : mag;
    if (w4.grp) begin
      case (w4.cmd)
        CMD_FIRST: begin
          n5.v  = sat32(64'(w4.v) + dv);
          n5.ve = remap ? sat32(dv) : sat32(64'(w4.v) + (dv <<< 1));
        end
        CMD_SECOND:  n5.v = sat32(64'(w4.v) + dv);
        CMD_CORRECT: if (remap) n5.ve = sat32(64'(w4.ve) + 64'(w4.v));
        default: ;
      endcase
    end
  end

  always_comb begin
    n6       = w5;
    n6.x_neg = w5.v[DATA_W-1];
    n6.px    = PROD_W'(dtv) * PROD_W'(mag32(w5.v));
  end

  always_comb begin
    n7 = w6;
    if (w6.grp && w6.cmd == CMD_FIRST) begin
      n7.x = sat32(64'(w6.x) + mulq_fin(w6.px, w6.x_neg, FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= w_in;
      w2 <= n2;
      w3 <= n3;
      w5 <= n5;
      w6 <= n6;
      w7 <= n7;
    end
  end

  assign rsp.valid                 = v7;
  assign rsp.new_position          = w7.x;
  assign rsp.new_velocity          = w7.v;
  assign rsp.new_velocity_estimate = w7.ve;
  assign rsp.new_density           = w7.rho;
  assign rsp.new_energy            = w7.e;

endmodule
`default_nettype wire
